/* rtl/core/prs_pkg.sv */
package prs_pkg;

	localparam int unsigned ROUNDS = 31;
	localparam int unsigned BLOCK_W = 64;
	localparam int unsigned KEY_W = 80;
	localparam int unsigned RND_W = 5;

	typedef logic [BLOCK_W-1:0] block_t;
	typedef logic [KEY_W-1:0] key_t;
	typedef logic [RND_W-1:0] rnd_t;

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_KEY_LOW  = 1'b0,
		REG_KEY_HIGH = 1'b1
	} reg_idx_t;

	localparam logic [3:0] SBOX [16] = '{
		4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
		4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
	};

	function automatic block_t sub_layer(input block_t s);
		block_t r;
		r = '0;
		for (int n = 0; n < 16; n++) begin
			r[4*n +: 4] = SBOX[s[4*n +: 4]];
		end
		return r;
	endfunction

	// bit i moves to 16*i mod 63, the top bit stays
	function automatic block_t perm_layer(input block_t s);
		block_t r;
		r = '0;
		for (int i = 0; i < 63; i++) begin
			r[(16 * i) % 63] = s[i];
		end
		r[63] = s[63];
		return r;
	endfunction

	function automatic block_t round_key(input key_t k);
		return k[79:16];
	endfunction

	// rotate left by 61, S-box on the top nibble, counter into bits 19..15
	function automatic key_t key_update(input key_t k, input rnd_t rnd);
		key_t n;
		n = {k[18:0], k[79:19]};
		n[79:76] = SBOX[n[79:76]];
		n[19:15] = n[19:15] ^ rnd;
		return n;
	endfunction

endpackage

/* rtl/core/prs_pt_if.sv */
interface prs_pt_if;
	logic valid;
	logic ready;
	logic [63:0] plaintext;

	modport source (output valid, output plaintext, input ready);
	modport sink (input valid, input plaintext, output ready);
endinterface

/* rtl/core/prs_ct_if.sv */
interface prs_ct_if;
	logic valid;
	logic ready;
	logic [63:0] ciphertext;

	modport source (output valid, output ciphertext, input ready);
	modport sink (input valid, input ciphertext, output ready);
endinterface

/* rtl/core/prs_round.sv */
module prs_round (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  prs_pkg::rnd_t   rnd,
	input  logic            in_valid,
	input  prs_pkg::block_t in_state,
	input  prs_pkg::key_t   in_key,
	output logic            valid_s,
	output prs_pkg::block_t state_s,
	output prs_pkg::key_t   key_s
);

	prs_pkg::block_t state_d;
	prs_pkg::key_t key_d;

	always_comb begin
		state_d = prs_pkg::perm_layer(prs_pkg::sub_layer(in_state ^ prs_pkg::round_key(in_key)));
		key_d = prs_pkg::key_update(in_key, rnd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else if (adv) begin
			valid_s <= in_valid;
		end
	end

	// payload needs no reset; load only on a live transaction
	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			state_s <= state_d;
			key_s <= key_d;
		end
	end

endmodule

/* rtl/core/present80_block_encrypt.sv */
// PRESENT-80 block encryption, one 64-bit block per transaction.
// plain_blk (sink) takes a plaintext block, cipher_blk (source) returns the
// ciphertext block; both use valid/ready, a transaction completes on a clock
// edge with both high. Bytes are little-endian: byte 0 sits in bits 7..0.
// The 80-bit key is loaded through cfg_we/cfg_index/cfg_wdata: index 0 holds
// key bits 63..0, index 1 key bits 79..64 (low 16 bits of cfg_wdata). Load
// the key only while no block is in flight.
// The accepting edge loads the first of 31 round stages, each doing round-key
// addition, S-box layer, permutation and the next round key; the output
// register then takes the final key addition and holds the result. The round
// key travels with its block.
// Throughput: one block per cycle when the receiver keeps ready high.
// When the receiver stalls, each stage holds only while the stage after it is
// full, so bubbles close up and input keeps being taken until every stage is
// occupied. Reset clears all stage valid bits and sets the key to zero.
module present80_block_encrypt (
	input  logic          clk,
	input  logic          arst_n,
	prs_pt_if.sink        plain_blk,
	prs_ct_if.source      cipher_blk,
	input  logic          cfg_we,
	input  prs_pkg::reg_idx_t cfg_index,
	input  logic [63:0]   cfg_wdata
);

	localparam int unsigned N = prs_pkg::ROUNDS;

	logic [63:0] key_low_q;
	logic [15:0] key_high_q;

	logic            stage_valid [N+1];
	prs_pkg::block_t stage_state [N+1];
	prs_pkg::key_t   stage_key [N+1];
	logic            stage_adv [N+2];

	logic            out_valid_q;
	prs_pkg::block_t ciphertext_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q <= '0;
			key_high_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				prs_pkg::REG_KEY_LOW:  key_low_q <= cfg_wdata;
				prs_pkg::REG_KEY_HIGH: key_high_q <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	assign stage_valid[0] = plain_blk.valid;
	assign stage_state[0] = plain_blk.plaintext;
	assign stage_key[0] = {key_high_q, key_low_q};

	// a stage advances when it is empty or the stage after it advances
	assign stage_adv[N+1] = !out_valid_q || cipher_blk.ready;

	for (genvar r = 1; r <= N; r++) begin : g_round
		assign stage_adv[r] = !stage_valid[r] || stage_adv[r+1];

		prs_round u_round (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (stage_adv[r]),
			.rnd      (prs_pkg::rnd_t'(r)),
			.in_valid (stage_valid[r-1]),
			.in_state (stage_state[r-1]),
			.in_key   (stage_key[r-1]),
			.valid_s  (stage_valid[r]),
			.state_s  (stage_state[r]),
			.key_s    (stage_key[r])
		);
	end

	assign stage_adv[0] = stage_adv[1];
	assign plain_blk.ready = stage_adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stage_adv[N+1]) begin
			out_valid_q <= stage_valid[N];
		end
	end

	// final key addition
	always_ff @(posedge clk) begin
		if (stage_adv[N+1] && stage_valid[N]) begin
			ciphertext_q <= stage_state[N] ^ prs_pkg::round_key(stage_key[N]);
		end
	end

	assign cipher_blk.valid = out_valid_q;
	assign cipher_blk.ciphertext = ciphertext_q;

endmodule
